// ===== hw/rtl/qtbe_pkg.sv =====
package qtbe_pkg;

    localparam int unsigned CFG_W = 9;
    localparam logic CFG_IDX_ROWS = 1'b0;
    localparam logic CFG_IDX_COLS = 1'b1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_PULL = 1'b1;

    localparam logic [1:0] SYM_ZERO  = 2'd0;
    localparam logic [1:0] SYM_ONE   = 2'd1;
    localparam logic [1:0] SYM_SPLIT = 2'd2;

    typedef enum logic [3:0] {
        t_ST_LOAD,
        t_ST_IDLE,
        t_ST_FIRST,
        t_ST_SCAN,
        t_ST_DECIDE,
        t_ST_ADV,
        t_ST_POP,
        t_ST_OUT,
        t_ST_DONE
    } t_state;

    typedef struct packed {
        logic load_px;
        logic restart;
        logic sel_root;
        logic scan_start;
        logic scan_step;
        logic push;
        logic bump_top;
        logic pop;
        logic set_sym;
        logic mark_split;
    } t_cmd;

    typedef struct packed {
        logic load_last;
        logic scan_end;
        logic mismatch;
        logic stack_empty;
        logic stack_full;
        logic child_empty;
        logic top_next_end;
    } t_sts;

endpackage

// ===== hw/rtl/qtbe_if.sv =====
interface qtbe_in_if;
    logic valid;
    logic ready;
    logic operation;
    logic pixel_value;
    modport source (output valid, output operation, output pixel_value, input ready);
    modport sink (input valid, input operation, input pixel_value, output ready);
endinterface

interface qtbe_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] code_symbol;
    logic       last_symbol;
    modport source (output valid, output code_symbol, output last_symbol, input ready);
    modport sink (input valid, input code_symbol, input last_symbol, output ready);
endinterface

// ===== hw/rtl/qtbe_datapath.sv =====
module qtbe_datapath #(
    parameter int unsigned MAX_DIM     = 256,
    parameter int unsigned STACK_DEPTH = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [qtbe_pkg::CFG_W-1:0]     i_rows,
    input  logic [qtbe_pkg::CFG_W-1:0]     i_cols,
    input  logic                           i_pixel,
    input  qtbe_pkg::t_cmd                 i_cmd,
    output qtbe_pkg::t_sts                 o_sts,
    output logic [1:0]                     o_sym
);
    localparam int unsigned DW = $clog2(MAX_DIM + 1);
    localparam int unsigned CW = (DW > qtbe_pkg::CFG_W) ? DW : qtbe_pkg::CFG_W;
    localparam int unsigned AW = $clog2(MAX_DIM * MAX_DIM);
    localparam int unsigned PW = $clog2(MAX_DIM * MAX_DIM + 1);
    localparam int unsigned SW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned XW = $clog2(STACK_DEPTH);
    localparam logic [CW-1:0] MAXV = CW'(MAX_DIM);

    logic [CW-1:0] w_rx, w_cx;
    logic [DW-1:0] w_er, w_ec;
    assign w_rx = CW'(i_rows);
    assign w_cx = CW'(i_cols);
    assign w_er = (w_rx > MAXV) ? DW'(MAX_DIM) : DW'(w_rx);
    assign w_ec = (w_cx > MAXV) ? DW'(MAX_DIM) : DW'(w_cx);

    logic       r_mem [MAX_DIM*MAX_DIM];
    logic       r_rd;
    logic [AW-1:0] w_raddr;

    // load pointer, compare against image size
    logic [PW-1:0] r_lp;
    logic [PW-1:0] w_total;
    assign w_total = PW'(w_er * w_ec);
    assign o_sts.load_last = (r_lp + PW'(1)) >= w_total;

    // stack of frames
    logic [DW-1:0] r_sr [STACK_DEPTH];
    logic [DW-1:0] r_sc [STACK_DEPTH];
    logic [DW-1:0] r_st [STACK_DEPTH];
    logic [DW-1:0] r_sl [STACK_DEPTH];
    logic [2:0]    r_sn [STACK_DEPTH];
    logic [SW-1:0] r_lvl;
    logic [XW-1:0] w_ti;
    assign w_ti = XW'(r_lvl - SW'(1));
    assign o_sts.stack_empty = (r_lvl == '0);
    assign o_sts.stack_full  = (r_lvl == SW'(STACK_DEPTH));

    // child of top frame
    logic [DW-1:0] w_pr, w_pc, w_rc, w_rf, w_cc, w_cf;
    logic [2:0]    w_k;
    logic [DW-1:0] w_gr, w_gc, w_gt, w_gl;
    always_comb begin
        w_pr = r_sr[w_ti];
        w_pc = r_sc[w_ti];
        w_k  = r_sn[w_ti];
        w_rc = DW'(({1'b0, w_pr} + 1'b1) >> 1);
        w_rf = w_pr >> 1;
        w_cc = DW'(({1'b0, w_pc} + 1'b1) >> 1);
        w_cf = w_pc >> 1;
        w_gr = (w_k < 3'd2) ? w_rc : w_rf;
        w_gc = (w_k[0] == 1'b0) ? w_cc : w_cf;
        w_gt = r_st[w_ti] + ((w_k < 3'd2) ? '0 : w_rc);
        w_gl = r_sl[w_ti] + ((w_k[0] == 1'b0) ? '0 : w_cc);
    end
    assign o_sts.child_empty  = (w_gr == '0) || (w_gc == '0);
    assign o_sts.top_next_end = (w_k == 3'd4);

    // current region and scan
    logic [DW-1:0] r_gr, r_gc, r_gt, r_gl;
    logic [DW-1:0] r_r, r_c;
    logic          r_first;
    logic [1:0]    r_sym;
    logic [AW:0]   w_prod;
    logic          w_at_end;
    assign w_prod  = (AW+1)'(r_r * w_ec) + (AW+1)'(r_c);
    assign w_raddr = i_cmd.load_px ? AW'(r_lp) : AW'(w_prod);
    assign w_at_end = (r_c + DW'(1) == r_gl + r_gc) && (r_r + DW'(1) == r_gt + r_gr);
    logic r_end;
    assign o_sts.scan_end = r_end;
    assign o_sts.mismatch = (r_rd != r_first);
    assign o_sym = r_sym;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_px) begin
            r_mem[w_raddr] <= i_pixel;
        end
        r_rd <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_lp  <= '0;
            r_lvl <= '0;
        end else begin
            if (i_cmd.load_px) r_lp <= r_lp + PW'(1);
            if (i_cmd.push) begin
                r_lvl <= r_lvl + SW'(1);
            end else if (i_cmd.pop) begin
                r_lvl <= r_lvl - SW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_sr[XW'(r_lvl)] <= r_gr;
            r_sc[XW'(r_lvl)] <= r_gc;
            r_st[XW'(r_lvl)] <= r_gt;
            r_sl[XW'(r_lvl)] <= r_gl;
            r_sn[XW'(r_lvl)] <= 3'd0;
        end
        if (i_cmd.bump_top) begin
            r_sn[w_ti] <= r_sn[w_ti] + 3'd1;
        end
        if (i_cmd.pop && r_lvl > SW'(1)) begin
            r_sn[XW'(r_lvl - SW'(2))] <= r_sn[XW'(r_lvl - SW'(2))] + 3'd1;
        end
        if (i_cmd.scan_start) begin
            if (i_cmd.sel_root) begin
                r_gr <= w_er; r_gc <= w_ec; r_gt <= '0; r_gl <= '0;
                r_r  <= '0;   r_c  <= '0;
            end else begin
                r_gr <= w_gr; r_gc <= w_gc; r_gt <= w_gt; r_gl <= w_gl;
                r_r  <= w_gt; r_c  <= w_gl;
            end
            r_end <= 1'b0;
        end
        if (i_cmd.scan_step) begin
            // step to the next pixel of the region, wrapping to its next row
            if (r_c + DW'(1) == r_gl + r_gc) begin
                r_c <= r_gl;
                r_r <= r_r + DW'(1);
            end else begin
                r_c <= r_c + DW'(1);
            end
            r_end <= w_at_end;
        end
        if (i_cmd.set_sym) begin
            r_first <= r_rd;
            r_sym   <= r_rd ? qtbe_pkg::SYM_ONE : qtbe_pkg::SYM_ZERO;
        end
        if (i_cmd.mark_split) begin
            r_sym <= qtbe_pkg::SYM_SPLIT;
        end
    end

`ifndef SYNTHESIS
    a_lvl_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lvl <= SW'(STACK_DEPTH)) else $error("stack level overflow");
    a_no_push_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.push && i_cmd.pop)) else $error("push and pop together");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> r_lvl != '0) else $error("pop on empty stack");
`endif
endmodule

// ===== hw/rtl/qtbe_ctrl.sv =====
module qtbe_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_restart,
    input  logic            i_zero_dim,
    input  logic            i_in_valid,
    input  logic            i_in_op,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output logic            o_last,
    input  logic            i_out_ready,
    input  qtbe_pkg::t_sts  i_sts,
    output qtbe_pkg::t_cmd  o_cmd
);
    qtbe_pkg::t_state r_state, n_state;
    logic r_root, n_root, r_last, n_last;

    logic w_take;
    assign w_take = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_root  = r_root;
        n_last  = r_last;
        case (r_state)
            qtbe_pkg::t_ST_LOAD: begin
                if (w_take && i_in_op == qtbe_pkg::OP_LOAD && i_sts.load_last)
                    n_state = qtbe_pkg::t_ST_IDLE;
            end
            qtbe_pkg::t_ST_IDLE: begin
                if (w_take && i_in_op == qtbe_pkg::OP_PULL)
                    n_state = qtbe_pkg::t_ST_FIRST;
            end
            qtbe_pkg::t_ST_FIRST: n_state = qtbe_pkg::t_ST_SCAN;
            qtbe_pkg::t_ST_SCAN: begin
                // single-pixel region: the first pixel decides it
                if (i_sts.scan_end) begin
                    n_state = qtbe_pkg::t_ST_ADV;
                    n_root  = 1'b0;
                end else begin
                    n_state = qtbe_pkg::t_ST_DECIDE;
                end
            end
            qtbe_pkg::t_ST_DECIDE: begin
                if (i_sts.mismatch || i_sts.scan_end) begin
                    n_state = qtbe_pkg::t_ST_ADV;
                    n_root  = 1'b0;
                end
            end
            qtbe_pkg::t_ST_ADV: begin
                if (i_sts.stack_empty) begin
                    n_last  = 1'b1;
                    n_state = qtbe_pkg::t_ST_OUT;
                end else if (i_sts.top_next_end) begin
                    n_state = qtbe_pkg::t_ST_POP;
                end else if (!i_sts.child_empty) begin
                    n_last  = 1'b0;
                    n_state = qtbe_pkg::t_ST_OUT;
                end
            end
            qtbe_pkg::t_ST_POP: n_state = qtbe_pkg::t_ST_ADV;
            qtbe_pkg::t_ST_OUT: begin
                if (i_out_ready)
                    n_state = r_last ? qtbe_pkg::t_ST_DONE : qtbe_pkg::t_ST_IDLE;
            end
            qtbe_pkg::t_ST_DONE: n_state = qtbe_pkg::t_ST_DONE;
            default: n_state = qtbe_pkg::t_ST_LOAD;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_last      = r_last;
        case (r_state)
            qtbe_pkg::t_ST_LOAD: begin
                o_in_ready    = 1'b1;
                o_cmd.load_px = w_take && i_in_op == qtbe_pkg::OP_LOAD;
            end
            qtbe_pkg::t_ST_IDLE: begin
                o_in_ready       = 1'b1;
                o_cmd.scan_start = w_take && i_in_op == qtbe_pkg::OP_PULL;
                o_cmd.sel_root   = r_root;
            end
            // address of first pixel is presented; read returns next cycle
            qtbe_pkg::t_ST_FIRST: o_cmd.scan_step = 1'b1;
            qtbe_pkg::t_ST_SCAN: begin
                o_cmd.set_sym   = 1'b1;
                o_cmd.scan_step = !i_sts.scan_end;
                o_cmd.bump_top  = i_sts.scan_end && !r_root;
            end
            qtbe_pkg::t_ST_DECIDE: begin
                o_cmd.scan_step = !(i_sts.mismatch || i_sts.scan_end);
                if (i_sts.mismatch) begin
                    o_cmd.mark_split = 1'b1;
                    if (!i_sts.stack_full) o_cmd.push = 1'b1;
                    else if (!r_root) o_cmd.bump_top = 1'b1;
                    else begin
                        o_cmd.bump_top = 1'b0;
                    end
                end else if (i_sts.scan_end && !r_root) begin
                    o_cmd.bump_top = 1'b1;
                end
            end
            qtbe_pkg::t_ST_ADV: begin
                if (!i_sts.stack_empty && !i_sts.top_next_end && i_sts.child_empty)
                    o_cmd.bump_top = 1'b1;
            end
            qtbe_pkg::t_ST_POP: o_cmd.pop = 1'b1;
            qtbe_pkg::t_ST_OUT: o_out_valid = 1'b1;
            qtbe_pkg::t_ST_DONE: o_in_ready = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_state <= i_zero_dim ? qtbe_pkg::t_ST_DONE : qtbe_pkg::t_ST_LOAD;
            r_root  <= 1'b1;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_root  <= n_root;
            r_last  <= n_last;
        end
    end

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n || i_restart)
        o_out_valid && !i_out_ready |=> o_out_valid) else $error("result dropped");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("input taken while result pending");
    a_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.scan_start |-> !o_cmd.load_px) else $error("load during scan start");
`endif
endmodule

// ===== hw/rtl/quadtree_bitmap_encoder.sv =====
// Quadtree bitmap encoder.
// Channels: in_ch carries beats {operation, pixel_value}; out_ch carries
// {code_symbol, last_symbol}. Config port (i_cfg_we, i_cfg_idx, i_cfg_data)
// writes image_rows (0) or image_cols (1); a write restarts loading.
// Load beats: one pixel per cycle, row-major, image_rows*image_cols beats,
// each dimension clamped to MAX_DIM. A pull beat makes the block scan the
// region in the bitmap RAM one pixel per cycle, set by the single RAM read
// port; it stops early when a differing pixel turns up. The symbol is
// then offered once empty quadrants are skipped and finished stack frames
// are popped. The next pull is taken the cycle after the symbol leaves.
// A pull with no symbol gives no output beat.
// While a symbol waits on out_ch, in_ch is held not ready; a stalled
// receiver simply holds the block. Reset (sync, active low) sets 1x1 image,
// empty stack, loading phase. The RAM has no reset; all read pixels are
// loaded first.
module quadtree_bitmap_encoder #(
    parameter int unsigned MAX_DIM     = 256,
    parameter int unsigned STACK_DEPTH = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [qtbe_pkg::CFG_W-1:0] i_cfg_data,
    qtbe_in_if.sink                    in_ch,
    qtbe_out_if.source                 out_ch
);
    logic [qtbe_pkg::CFG_W-1:0] r_rows, r_cols, w_nr, w_nc;
    logic w_restart;

    assign w_restart = i_cfg_we;
    assign w_nr = (i_cfg_we && i_cfg_idx == qtbe_pkg::CFG_IDX_ROWS) ? i_cfg_data : r_rows;
    assign w_nc = (i_cfg_we && i_cfg_idx == qtbe_pkg::CFG_IDX_COLS) ? i_cfg_data : r_cols;

    // hold the registers; a write restarts the load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= qtbe_pkg::CFG_W'(1);
            r_cols <= qtbe_pkg::CFG_W'(1);
        end else begin
            r_rows <= w_nr;
            r_cols <= w_nc;
        end
    end

    qtbe_pkg::t_cmd w_cmd;
    qtbe_pkg::t_cmd w_dp_cmd;
    qtbe_pkg::t_sts w_sts;
    logic [1:0] w_sym;
    logic w_zero;
    // zero check uses the value about to be stored
    assign w_zero = (w_nr == '0) || (w_nc == '0) || !i_rst_n ? ((w_nr == '0 || w_nc == '0)
                    && i_rst_n) : 1'b0;

    // a config write also clears the load pointer and the stack
    always_comb begin
        w_dp_cmd         = w_cmd;
        w_dp_cmd.restart = w_restart;
    end

    qtbe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (w_restart),
        .i_zero_dim  (w_zero),
        .i_in_valid  (in_ch.valid),
        .i_in_op     (in_ch.operation),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_ch.valid),
        .o_last      (out_ch.last_symbol),
        .i_out_ready (out_ch.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    qtbe_datapath #(.MAX_DIM(MAX_DIM), .STACK_DEPTH(STACK_DEPTH)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rows  (r_rows),
        .i_cols  (r_cols),
        .i_pixel (in_ch.pixel_value),
        .i_cmd   (w_dp_cmd),
        .o_sts   (w_sts),
        .o_sym   (w_sym)
    );

    assign out_ch.code_symbol = w_sym;

`ifndef SYNTHESIS
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> out_ch.code_symbol != 2'd3) else $error("bad symbol code");
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n || i_cfg_we)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.code_symbol)
        && $stable(out_ch.last_symbol)) else $error("output beat changed while stalled");
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !out_ch.valid) else $error("output after restart");
`endif
endmodule
